@@ src/fpdf_pkg.sv @@
// Shared types, constants and helper functions of the fixed-point decimal formatter.
package fpdf_pkg;

    localparam int MAX_WIDTH_DEF  = 16;
    localparam int VALUE_BITS_DEF = 32;
    localparam int FRAC_LIMIT     = 9;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAC_DIGITS = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CONV = 7'b0000010,
        S_SCAN = 7'b0000100,
        S_SIGN = 7'b0001000,
        S_PAD  = 7'b0010000,
        S_DIG  = 7'b0100000,
        S_DOT  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } bcd_ctrl_t;

    typedef struct packed {
        logic       done;
        logic [3:0] digit;
    } bcd_stat_t;

    // Decimal digits needed for any unsigned value of the given bit count.
    function automatic int num_digits(input int bits);
        return ((bits * 1233) >> 12) + 1;
    endfunction

    // Digit positions the printer can address, including leading zeros of the fraction.
    function automatic int num_positions(input int bits);
        int nd;
        nd = num_digits(bits);
        return (nd > FRAC_LIMIT + 1) ? nd : FRAC_LIMIT + 1;
    endfunction

endpackage

@@ src/fpdf_bcd_unit.sv @@
// Shared shift and add-three unit that converts the magnitude to decimal digits.
module fpdf_bcd_unit #(
    parameter int VALUE_BITS = fpdf_pkg::VALUE_BITS_DEF,
    parameter int PTR_W      = $clog2(fpdf_pkg::num_positions(VALUE_BITS))
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  fpdf_pkg::bcd_ctrl_t       ctrl,
    input  logic [VALUE_BITS-1:0]     mag,
    input  logic [PTR_W-1:0]          ptr,
    output fpdf_pkg::bcd_stat_t       stat
);

    localparam int NDIG  = fpdf_pkg::num_digits(VALUE_BITS);
    localparam int DIG_W = $clog2(NDIG);
    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic [3:0]            dig_reg [NDIG];
    logic [3:0]            dig_next [NDIG];
    logic [3:0]            adj [NDIG];
    logic [VALUE_BITS-1:0] bin_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            adj[i] = (dig_reg[i] >= 4'd5) ? dig_reg[i] + 4'd3 : dig_reg[i];
        end
        dig_next[0] = {adj[0][2:0], bin_reg[VALUE_BITS-1]};
        for (int i = 1; i < NDIG; i++)
        begin
            dig_next[i] = {adj[i][2:0], adj[i-1][3]};
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctrl.load)
        begin
            cnt_next = CNT_W'(VALUE_BITS);
        end
        else if (ctrl.step)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            bin_reg <= mag;
            for (int i = 0; i < NDIG; i++)
            begin
                dig_reg[i] <= 4'd0;
            end
        end
        else if (ctrl.step)
        begin
            bin_reg <= {bin_reg[VALUE_BITS-2:0], 1'b0};
            for (int i = 0; i < NDIG; i++)
            begin
                dig_reg[i] <= dig_next[i];
            end
        end
    end

    always_comb
    begin
        stat.done  = (cnt_reg == '0);
        stat.digit = 4'd0;
        if (32'(ptr) < NDIG)
        begin
            stat.digit = dig_reg[ptr[DIG_W-1:0]];
        end
    end

endmodule

@@ src/fpdf_seq.sv @@
// Sequencer that drives the conversion unit and emits the characters through an output register.
module fpdf_seq #(
    parameter int MAX_WIDTH  = fpdf_pkg::MAX_WIDTH_DEF,
    parameter int VALUE_BITS = fpdf_pkg::VALUE_BITS_DEF,
    parameter int PTR_W      = $clog2(fpdf_pkg::num_positions(VALUE_BITS))
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [4:0]                   min_width,
    input  logic [3:0]                   frac_digits,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [VALUE_BITS-1:0] scaled_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   ascii_char,
    output logic                         last_char,
    output fpdf_pkg::bcd_ctrl_t          ctrl,
    output logic [VALUE_BITS-1:0]        mag,
    output logic [PTR_W-1:0]             ptr,
    input  fpdf_pkg::bcd_stat_t          stat
);

    localparam int NPOS  = fpdf_pkg::num_positions(VALUE_BITS);
    localparam int LIM   = (MAX_WIDTH > NPOS + 1) ? MAX_WIDTH : NPOS + 1;
    localparam int CNT_W = $clog2(LIM + 1);

    fpdf_pkg::state_t state_reg, state_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] pad_reg, pad_next;
    logic [CNT_W-1:0] width_reg, width_next;
    logic [3:0]       frac_reg, frac_next;
    logic             neg_reg, neg_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;

    logic [VALUE_BITS-1:0] raw;
    logic [CNT_W-1:0]      used;
    logic [CNT_W-1:0]      pad_calc;
    logic                  slot_free;

    assign raw       = VALUE_BITS'(scaled_value);
    assign mag       = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
    assign ptr       = ptr_reg;
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == fpdf_pkg::S_IDLE);
    assign used      = CNT_W'(ptr_reg) + CNT_W'(1) + CNT_W'(frac_reg != 4'd0);
    assign pad_calc  = (width_reg > used) ? width_reg - used : '0;

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        pad_next       = pad_reg;
        width_next     = width_reg;
        frac_next      = frac_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        ctrl           = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            fpdf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    neg_next   = raw[VALUE_BITS-1];
                    frac_next  = (32'(frac_digits) > fpdf_pkg::FRAC_LIMIT)
                                 ? 4'(fpdf_pkg::FRAC_LIMIT) : frac_digits;
                    width_next = (32'(min_width) > MAX_WIDTH)
                                 ? CNT_W'(MAX_WIDTH) : CNT_W'(min_width);
                    ptr_next   = PTR_W'(NPOS - 1);
                    state_next = fpdf_pkg::S_CONV;
                end
            end
            fpdf_pkg::S_CONV:
            begin
                if (stat.done)
                begin
                    state_next = fpdf_pkg::S_SCAN;
                end
                else
                begin
                    ctrl.step = 1'b1;
                end
            end
            fpdf_pkg::S_SCAN:
            begin
                if (CNT_W'(ptr_reg) > CNT_W'(frac_reg) && stat.digit == 4'd0)
                begin
                    ptr_next = ptr_reg - PTR_W'(1);
                end
                else
                begin
                    pad_next = pad_calc;
                    if (neg_reg)
                    begin
                        state_next = fpdf_pkg::S_SIGN;
                    end
                    else if (pad_calc != '0)
                    begin
                        state_next = fpdf_pkg::S_PAD;
                    end
                    else
                    begin
                        state_next = fpdf_pkg::S_DIG;
                    end
                end
            end
            fpdf_pkg::S_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = fpdf_pkg::CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = (pad_reg != '0) ? fpdf_pkg::S_PAD : fpdf_pkg::S_DIG;
                end
            end
            fpdf_pkg::S_PAD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = fpdf_pkg::CHAR_ZERO;
                    last_next      = 1'b0;
                    pad_next       = pad_reg - CNT_W'(1);
                    if (pad_reg == CNT_W'(1))
                    begin
                        state_next = fpdf_pkg::S_DIG;
                    end
                end
            end
            fpdf_pkg::S_DIG:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = fpdf_pkg::CHAR_ZERO + {4'b0000, stat.digit};
                    last_next      = (ptr_reg == '0);
                    if (ptr_reg == '0)
                    begin
                        state_next = fpdf_pkg::S_IDLE;
                    end
                    else if (frac_reg != 4'd0 && CNT_W'(ptr_reg) == CNT_W'(frac_reg))
                    begin
                        state_next = fpdf_pkg::S_DOT;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - PTR_W'(1);
                    end
                end
            end
            fpdf_pkg::S_DOT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = fpdf_pkg::CHAR_DOT;
                    last_next      = 1'b0;
                    ptr_next       = ptr_reg - PTR_W'(1);
                    state_next     = fpdf_pkg::S_DIG;
                end
            end
            default:
            begin
                state_next = fpdf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fpdf_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        pad_reg   <= pad_next;
        width_reg <= width_next;
        frac_reg  <= frac_next;
        neg_reg   <= neg_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign ascii_char = char_reg;
    assign last_char  = last_reg;

endmodule

@@ src/fixed_point_decimal_formatter_unit.sv @@
// Top level of the fixed-point decimal formatter: configuration registers and unit wiring.
// Conversion shifts all VALUE_BITS bits of the magnitude through the BCD unit, then a
// leading-zero scan steps down from the top digit position, then one character per cycle
// is emitted while the output is taken.
// The next number is accepted once the last character sits in the output register.
// Reset clears min_width and frac_digits to zero and returns the sequencer to idle.
module fixed_point_decimal_formatter_unit #(
    parameter int MAX_WIDTH  = fpdf_pkg::MAX_WIDTH_DEF,
    parameter int VALUE_BITS = fpdf_pkg::VALUE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [fpdf_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [fpdf_pkg::CFG_DATA_W-1:0]    wr_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [VALUE_BITS-1:0]       scaled_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         ascii_char,
    output logic                               last_char
);

    localparam int PTR_W = $clog2(fpdf_pkg::num_positions(VALUE_BITS));

    logic [4:0] min_width_reg, min_width_next;
    logic [3:0] frac_digits_reg, frac_digits_next;

    fpdf_pkg::bcd_ctrl_t   ctrl;
    fpdf_pkg::bcd_stat_t   stat;
    logic [VALUE_BITS-1:0] mag;
    logic [PTR_W-1:0]      ptr;

    always_comb
    begin
        min_width_next   = min_width_reg;
        frac_digits_next = frac_digits_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                fpdf_pkg::REG_MIN_WIDTH:   min_width_next   = wr_data;
                fpdf_pkg::REG_FRAC_DIGITS: frac_digits_next = wr_data[3:0];
                default:                   min_width_next   = min_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_width_reg   <= '0;
            frac_digits_reg <= '0;
        end
        else
        begin
            min_width_reg   <= min_width_next;
            frac_digits_reg <= frac_digits_next;
        end
    end

    fpdf_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .VALUE_BITS (VALUE_BITS),
        .PTR_W      (PTR_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .min_width    (min_width_reg),
        .frac_digits  (frac_digits_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .scaled_value (scaled_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .ascii_char   (ascii_char),
        .last_char    (last_char),
        .ctrl         (ctrl),
        .mag          (mag),
        .ptr          (ptr),
        .stat         (stat)
    );

    fpdf_bcd_unit #(
        .VALUE_BITS (VALUE_BITS),
        .PTR_W      (PTR_W)
    ) u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .mag   (mag),
        .ptr   (ptr),
        .stat  (stat)
    );

endmodule
